// ----- hw/rtl/four_level_page_table_walker_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the four-level page table walker
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FPTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fptw_pkg.sv -----
// ----------------------------------------------------------------------------
// fptw_pkg
// Shared types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fptw_pkg;

  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ENTRY_W    = 64;
  localparam int unsigned VA_W       = 48;
  localparam int unsigned PA_W       = 52;
  localparam int unsigned FLAGS_W    = 12;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned FRAME_NUM_W = PA_W - PAGE_SHIFT;
  localparam int unsigned TABLE_ENTRIES = 512;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_MAP_4K    = 2'd1,
    OP_MAP_2M    = 2'd2,
    OP_UNMAP_4K  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_EMPTY = 2'd1,
    ST_HUGE_LEAF  = 2'd2
  } status_t;

  localparam logic [ENTRY_W-1:0] E_PRESENT = 64'h0000_0000_0000_0001;
  localparam logic [ENTRY_W-1:0] E_HUGE    = 64'h0000_0000_0000_0080;
  localparam logic [ENTRY_W-1:0] E_TABLE   = 64'h0000_0000_0000_0007;

endpackage

// ----- hw/rtl/four_level_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table store and walker: translate, map 4 KB, map 2 MB,
// unmap 4 KB, with on-the-fly allocation of table frames from a bump pool.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   in_operation, in_virt_addr, in_phys_addr and in_entry_flags are sampled
//   there. busy then stays high until the result is out.
//   Each transaction returns exactly one result: out_valid is high for one
//   cycle with out_result_phys, out_found and out_status. There is no
//   backpressure on the result side; the receiver must take it.
//   The walk visits up to four levels through the single read port of the
//   table RAM, each level in an S_READ state (address) then an S_EVAL state
//   (registered data), with any table or leaf write done in S_EVAL. A
//   transaction ends soonest when the root entry is absent and runs longest
//   for a full 4 KB walk; the next transaction is accepted in the cycle
//   out_valid is shown.
//   Reset: after rst_n is released the table RAM is cleared, one entry per
//   cycle, POOL_FRAMES * 512 cycles; busy is high during that sweep. The
//   frame counter restarts at 1 (frame 0 is the root table).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_level_page_table_walker
  import fptw_pkg::*;
#(
  parameter int unsigned POOL_FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [VA_W-1:0]    in_virt_addr,
  input  logic [PA_W-1:0]    in_phys_addr,
  input  logic [FLAGS_W-1:0] in_entry_flags,
  output logic               out_valid,
  output logic [PA_W-1:0]    out_result_phys,
  output logic               out_found,
  output logic [1:0]         out_status
);

  localparam int unsigned FRAME_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int unsigned NF_W    = $clog2(POOL_FRAMES + 1);
  localparam int unsigned DEPTH   = POOL_FRAMES * TABLE_ENTRIES;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [NF_W-1:0]   POOL_END  = NF_W'(POOL_FRAMES);
  localparam logic [FRAME_NUM_W-1:0] POOL_LIMIT = FRAME_NUM_W'(POOL_FRAMES);

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           lvl_r, lvl_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic                 oob_r, oob_nxt;
  logic [NF_W-1:0]      nf_r, nf_nxt;
  logic [ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  op_t                  op_r, op_nxt;
  logic [VA_W-1:0]      va_r, va_nxt;
  logic [PA_W-1:0]      pa_r, pa_nxt;
  logic [FLAGS_W-1:0]   fl_r, fl_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]      res_r, res_nxt;
  logic                 found_r, found_nxt;
  status_t              status_r, status_nxt;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  logic [IDX_W-1:0]       idx;
  logic [ADDR_W-1:0]      cur_addr;
  logic [ENTRY_W-1:0]     entry;
  logic                   e_present;
  logic                   e_huge;
  logic [FRAME_NUM_W-1:0] e_frame;
  logic                   e_oob;
  logic [PA_W-1:0]        add_base;
  logic [PA_W-1:0]        add_ofs;
  logic [PA_W-1:0]        add_sum;
  logic                   create;
  logic                   pool_empty;
  logic [ENTRY_W-1:0]     new_table;

  fptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    case (lvl_r)
      LVL_PML4: idx = va_r[47:39];
      LVL_PDPT: idx = va_r[38:30];
      LVL_PD:   idx = va_r[29:21];
      default:  idx = va_r[20:12];
    endcase
  end

  assign cur_addr   = ADDR_W'({frame_r, idx});
  assign mem_raddr  = cur_addr;
  assign entry      = oob_r ? '0 : mem_rdata;
  assign e_present  = entry[0];
  assign e_huge     = entry[7];
  assign e_frame    = entry[PA_W-1:PAGE_SHIFT];
  assign e_oob      = (e_frame >= POOL_LIMIT);
  assign create     = (op_r == OP_MAP_4K) || (op_r == OP_MAP_2M);
  assign pool_empty = (nf_r >= POOL_END);
  assign new_table  = (ENTRY_W'(nf_r) << PAGE_SHIFT) | E_TABLE;

  // shared address adder: leaf base plus page or huge-page offset
  assign add_base = {e_frame, {PAGE_SHIFT{1'b0}}};
  assign add_ofs  = (lvl_r == LVL_PD) ? PA_W'(va_r[20:0]) : PA_W'(va_r[11:0]);
  assign add_sum  = add_base + add_ofs;

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    frame_nxt     = frame_r;
    oob_nxt       = oob_r;
    nf_nxt        = nf_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    va_nxt        = va_r;
    pa_nxt        = pa_r;
    fl_nxt        = fl_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_addr;
    mem_wdata     = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt     = op_t'(in_operation);
          va_nxt     = in_virt_addr;
          pa_nxt     = in_phys_addr;
          fl_nxt     = in_entry_flags;
          lvl_nxt    = LVL_PML4;
          frame_nxt  = '0;
          oob_nxt    = 1'b0;
          res_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        state_nxt = S_READ;
        if (lvl_r == LVL_PT) begin
          state_nxt = S_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == OP_TRANSLATE) begin
            if (e_present) begin
              res_nxt   = add_sum;
              found_nxt = 1'b1;
            end
          end else begin
            mem_we = !oob_r;
            if (op_r == OP_MAP_4K) begin
              mem_wdata = ENTRY_W'({pa_r[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}})
                        | ENTRY_W'(fl_r) | E_PRESENT;
            end
          end
        end else if (lvl_r == LVL_PD && op_r == OP_MAP_2M) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          mem_we        = !oob_r;
          mem_wdata     = ENTRY_W'(pa_r) | ENTRY_W'(fl_r) | E_HUGE;
        end else if (lvl_r == LVL_PD && e_present && e_huge) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == OP_TRANSLATE) begin
            res_nxt   = add_sum;
            found_nxt = 1'b1;
          end else begin
            status_nxt = ST_HUGE_LEAF;
          end
        end else if (e_present) begin
          lvl_nxt   = lvl_r + 2'd1;
          frame_nxt = e_frame[FRAME_W-1:0];
          oob_nxt   = e_oob;
        end else if (!create) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else if (pool_empty) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_POOL_EMPTY;
        end else begin
          mem_we    = !oob_r;
          mem_wdata = new_table;
          nf_nxt    = nf_r + NF_W'(1);
          lvl_nxt   = lvl_r + 2'd1;
          frame_nxt = nf_r[FRAME_W-1:0];
          oob_nxt   = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lvl_r    <= lvl_nxt;
    frame_r  <= frame_nxt;
    oob_r    <= oob_nxt;
    op_r     <= op_nxt;
    va_r     <= va_nxt;
    pa_r     <= pa_nxt;
    fl_r     <= fl_nxt;
    res_r    <= res_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      nf_r        <= NF_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_phys = res_r;
  assign out_found       = found_r;
  assign out_status      = status_r;

endmodule

// ----- hw/rtl/fptw_ram.sv -----
// ----------------------------------------------------------------------------
// fptw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/fptw_checker.sv -----
// ----------------------------------------------------------------------------
// fptw_checker
// Port-level checks of the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_level_page_table_walker_assert.svh"

module fptw_checker
  import fptw_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input logic [PA_W-1:0] out_result_phys,
  input logic            out_found,
  input logic [1:0]      out_status
);

  `FPTW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `FPTW_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while still busy")
  `FPTW_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `FPTW_ASSERT_NOW(a_found_ok, out_valid && out_found, out_status == ST_OK, "hit with error status")
  `FPTW_ASSERT_NOW(a_miss_zero, out_valid && !out_found, out_result_phys == '0, "miss with address")

endmodule

bind four_level_page_table_walker fptw_checker u_fptw_checker (.*);
